// ----- rtl/clcd_pkg.sv -----
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types and constants of the character display command stream decoder.
// ----------------------------------------------------------------------------
package clcd_pkg;

   localparam int GLYPH_COUNT_DEFAULT = 8;
   localparam int GLYPH_LINES         = 8;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [7:0] ESCAPE_BYTE = 8'hFF;

   // display address line ranges
   localparam logic [7:0] DD_LINE0_LO = 8'h80;
   localparam logic [7:0] DD_LINE0_HI = 8'h93;
   localparam logic [7:0] DD_LINE1_LO = 8'hC0;
   localparam logic [7:0] DD_LINE1_HI = 8'hD3;
   localparam logic [7:0] DD_LINE2_LO = 8'h94;
   localparam logic [7:0] DD_LINE2_HI = 8'hA7;
   localparam logic [7:0] DD_LINE3_LO = 8'hD4;
   localparam logic [7:0] DD_LINE3_HI = 8'hE7;

   localparam logic [7:0] PRINT_LO      = 8'h20;
   localparam logic [7:0] PRINT_HI      = 8'h7E;
   localparam logic [7:0] GLYPH_CODE_HI = 8'h07;

   localparam logic [7:0] ENTRY_MODE_RESET      = 8'h02;
   localparam logic [7:0] DISPLAY_CONTROL_RESET = 8'h04;
   localparam logic [7:0] SHIFT_CONTROL_RESET   = 8'h00;
   localparam logic [7:0] FUNCTION_SET_RESET    = 8'h26;
   localparam logic [7:0] ENTRY_INCREMENT_BIT   = 8'h02;

   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_CHAR  = 2'd1;
   localparam logic [1:0] KIND_ROW   = 2'd2;

   typedef enum logic [3:0] {
      OP_DATA,
      OP_CLEAR,
      OP_HOME,
      OP_ENTRY,
      OP_DISPLAY,
      OP_SHIFT,
      OP_FUNCTION,
      OP_CG_ADDR,
      OP_DD_ADDR
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] value;
   } entry_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_code;
      logic [7:0] column;
      logic [2:0] row;
      logic [2:0] glyph_line;
      logic [4:0] glyph_bits;
      logic       last;
      logic [7:0] entry_mode;
      logic [7:0] display_control;
      logic [7:0] shift_control;
      logic [7:0] function_set;
   } rsp_type;

   // remainder of a row number by the glyph count, by repeated subtraction
   function automatic logic [2:0] glyph_mod(input logic [2:0] value, input logic [3:0] count);
      logic [2:0] v;
      v = value;
      for (int i = 0; i < 8; i++) begin
         if ({1'b0, v} >= count) begin
            v = v - count[2:0];
         end
      end
      return v;
   endfunction

endpackage

// ----- rtl/clcd_front.sv -----
// ----------------------------------------------------------------------------
// clcd_front
// Takes input bytes, tracks the escape prefix and classifies each byte as
// data or as one command, then pushes it to the queue; the escape prefix and an escaped zero byte are not pushed.
// ----------------------------------------------------------------------------
module clcd_front
   import clcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       push,
   output entry_type  push_entry,
   input  logic       push_ready
);

   logic   escape_ff;
   logic   escape_in;
   logic   accept;
   op_type cmd_op;
   logic   cmd_none;

   assign req_stall = !push_ready;
   assign accept    = req_valid && push_ready;

   // highest set bit picks the command
   always_comb begin
      cmd_op   = OP_DD_ADDR;
      cmd_none = 1'b0;
      priority if (req_in_byte[7]) begin
         cmd_op = OP_DD_ADDR;
      end else if (req_in_byte[6]) begin
         cmd_op = OP_CG_ADDR;
      end else if (req_in_byte[5]) begin
         cmd_op = OP_FUNCTION;
      end else if (req_in_byte[4]) begin
         cmd_op = OP_SHIFT;
      end else if (req_in_byte[3]) begin
         cmd_op = OP_DISPLAY;
      end else if (req_in_byte[2]) begin
         cmd_op = OP_ENTRY;
      end else if (req_in_byte[1]) begin
         cmd_op = OP_HOME;
      end else if (req_in_byte[0]) begin
         cmd_op = OP_CLEAR;
      end else begin
         cmd_none = 1'b1;
      end
   end

   always_comb begin
      escape_in        = escape_ff;
      push             = 1'b0;
      push_entry.op    = OP_DATA;
      push_entry.value = req_in_byte;
      if (accept) begin
         if (escape_ff) begin
            escape_in     = 1'b0;
            push          = !cmd_none;
            push_entry.op = cmd_op;
         end else if (req_in_byte == ESCAPE_BYTE) begin
            escape_in = 1'b1;
         end else begin
            push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= 1'b0;
      end else begin
         escape_ff <= escape_in;
      end
   end

endmodule

// ----- rtl/clcd_queue.sv -----
// ----------------------------------------------------------------------------
// clcd_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module clcd_queue
   import clcd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      push_ready,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      pop_valid
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [AW-1:0]     wr_ptr_ff;
   logic [AW-1:0]     wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff;
   logic [AW-1:0]     rd_ptr_in;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = count_ff != CW'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/clcd_back.sv -----
// ----------------------------------------------------------------------------
// clcd_back
// Carries out queued commands and data: cursor and mode state, the glyph
// pattern memory, and the registered result slot.
// ----------------------------------------------------------------------------
module clcd_back
   import clcd_pkg::*;
#(
   parameter int GLYPH_COUNT = GLYPH_COUNT_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   input  entry_type pop_entry,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp
);

   localparam int DEPTH = GLYPH_COUNT * GLYPH_LINES;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_ROWS = 2'b10
   } state_type;

   state_type  state_ff, state_in;
   logic       target_ff, target_in;
   logic [7:0] col_ff, col_in;
   logic [2:0] row_ff, row_in;
   logic [7:0] entry_ff, entry_in;
   logic [7:0] display_ff, display_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] function_ff, function_in;
   logic [2:0] line_ff, line_in;
   logic [7:0] code_ff, code_in;
   logic       hit_ff, hit_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;

   logic [7:0]       mem [DEPTH];
   logic [DEPTH-1:0] mem_valid_ff;
   logic [7:0]       rd_data_ff;
   logic             rd_valid_ff;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;

   logic       out_free;
   logic [2:0] glyph;
   logic [2:0] glyph_next;
   logic [5:0] wr_full;
   logic [5:0] rd_full;
   logic [7:0] v;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign pop       = (state_ff == ST_IDLE) && pop_valid && out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;
   assign v         = pop_entry.value;

   assign glyph      = glyph_mod(row_ff, 4'(GLYPH_COUNT));
   assign glyph_next = ({1'b0, glyph} + 4'd1 == 4'(GLYPH_COUNT)) ? 3'd0 : glyph + 3'd1;
   assign wr_full    = {glyph, col_ff[2:0]};
   assign wr_addr    = wr_full[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      entry_in     = entry_ff;
      display_in   = display_ff;
      shift_in     = shift_ff;
      function_in  = function_ff;
      line_in      = line_ff;
      code_in      = code_ff;
      hit_in       = hit_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_in       = out_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_full      = {v[2:0], 3'd0};

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               unique case (pop_entry.op)
                  OP_DD_ADDR: begin
                     target_in = 1'b0;
                     if (v >= DD_LINE0_LO && v <= DD_LINE0_HI) begin
                        row_in = 3'd0;
                        col_in = v - DD_LINE0_LO;
                     end
                     if (v >= DD_LINE1_LO && v <= DD_LINE1_HI) begin
                        row_in = 3'd1;
                        col_in = v - DD_LINE1_LO;
                     end
                     if (v >= DD_LINE2_LO && v <= DD_LINE2_HI) begin
                        row_in = 3'd2;
                        col_in = v - DD_LINE2_LO;
                     end
                     if (v >= DD_LINE3_LO && v <= DD_LINE3_HI) begin
                        row_in = 3'd3;
                        col_in = v - DD_LINE3_LO;
                     end
                  end
                  OP_CG_ADDR: begin
                     target_in = 1'b1;
                     row_in    = v[5:3];
                     col_in    = 8'd0;
                  end
                  OP_FUNCTION: function_in = v;
                  OP_SHIFT:    shift_in    = v;
                  OP_DISPLAY:  display_in  = v;
                  OP_ENTRY:    entry_in    = v;
                  OP_HOME: begin
                     col_in = 8'd0;
                     row_in = 3'd0;
                  end
                  OP_CLEAR: begin
                     col_in                 = 8'd0;
                     row_in                 = 3'd0;
                     entry_in               = entry_ff | ENTRY_INCREMENT_BIT;
                     out_valid_in           = 1'b1;
                     out_in.kind            = KIND_CLEAR;
                     out_in.char_code       = 8'd0;
                     out_in.column          = 8'd0;
                     out_in.row             = 3'd0;
                     out_in.glyph_line      = 3'd0;
                     out_in.glyph_bits      = 5'd0;
                     out_in.last            = 1'b1;
                     out_in.entry_mode      = entry_ff | ENTRY_INCREMENT_BIT;
                     out_in.display_control = display_ff;
                     out_in.shift_control   = shift_ff;
                     out_in.function_set    = function_ff;
                  end
                  OP_DATA: begin
                     if (target_ff) begin
                        wr_en = 1'b1;
                        if (col_ff[2:0] == 3'd7) begin
                           col_in = 8'd0;
                           row_in = glyph_next;
                        end else begin
                           col_in = {5'd0, col_ff[2:0] + 3'd1};
                        end
                     end else if (v <= GLYPH_CODE_HI) begin
                        // custom glyph: first row read is issued now if the code is below GLYPH_COUNT
                        state_in = ST_ROWS;
                        line_in  = 3'd0;
                        code_in  = v;
                        hit_in   = v < 8'(GLYPH_COUNT);
                        rd_en    = v < 8'(GLYPH_COUNT);
                     end else if (v >= PRINT_LO && v <= PRINT_HI) begin
                        col_in                 = col_ff + 8'd1;
                        out_valid_in           = 1'b1;
                        out_in.kind            = KIND_CHAR;
                        out_in.char_code       = v;
                        out_in.column          = col_ff;
                        out_in.row             = row_ff;
                        out_in.glyph_line      = 3'd0;
                        out_in.glyph_bits      = 5'd0;
                        out_in.last            = 1'b1;
                        out_in.entry_mode      = entry_ff;
                        out_in.display_control = display_ff;
                        out_in.shift_control   = shift_ff;
                        out_in.function_set    = function_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ROWS: begin
            rd_full = {code_ff[2:0], line_ff + 3'd1};
            if (out_free) begin
               out_valid_in           = 1'b1;
               out_in.kind            = KIND_ROW;
               out_in.char_code       = code_ff;
               out_in.column          = col_ff;
               out_in.row             = row_ff;
               out_in.glyph_line      = line_ff;
               out_in.glyph_bits      = (hit_ff && rd_valid_ff) ? rd_data_ff[4:0] : 5'd0;
               out_in.last            = line_ff == 3'd7;
               out_in.entry_mode      = entry_ff;
               out_in.display_control = display_ff;
               out_in.shift_control   = shift_ff;
               out_in.function_set    = function_ff;
               if (line_ff == 3'd7) begin
                  state_in = ST_IDLE;
                  col_in   = col_ff + 8'd1;
               end else begin
                  line_in = line_ff + 3'd1;
                  rd_en   = hit_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_addr = rd_full[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= 1'b0;
         col_ff       <= 8'd0;
         row_ff       <= 3'd0;
         entry_ff     <= ENTRY_MODE_RESET;
         display_ff   <= DISPLAY_CONTROL_RESET;
         shift_ff     <= SHIFT_CONTROL_RESET;
         function_ff  <= FUNCTION_SET_RESET;
         out_valid_ff <= 1'b0;
         mem_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         entry_ff     <= entry_in;
         display_ff   <= display_in;
         shift_ff     <= shift_in;
         function_ff  <= function_in;
         out_valid_ff <= out_valid_in;
         if (wr_en) begin
            mem_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
      code_ff <= code_in;
      hit_ff  <= hit_in;
      out_ff  <= out_in;
   end

   // glyph pattern memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= v;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= mem_valid_ff[rd_addr];
      end
   end

endmodule

// ----- rtl/char_lcd_command_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// char_lcd_command_stream_decoder
// Byte stream decoder for a character display: commands, cursor, glyph store.
// ----------------------------------------------------------------------------
// The front takes one byte per cycle into a two-entry queue and stalls only
// when that queue is full. The back takes one queued byte per cycle while idle
// with its result slot free: commands, glyph-store writes and printable
// characters finish as they are taken; a custom glyph code starts the glyph
// memory read, then gives one pattern row per cycle from its single read port
// while the slot is free. An unescaped 0xFF (the escape prefix) and an escaped
// zero command are absorbed by the front and never reach the back. Results sit
// in an output register; the back waits only while it is full and stalled.
module char_lcd_command_stream_decoder
   import clcd_pkg::*;
#(
   parameter int GLYPH_COUNT = GLYPH_COUNT_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_char_code,
   output logic [7:0] rsp_column,
   output logic [2:0] rsp_row,
   output logic [2:0] rsp_glyph_line,
   output logic [4:0] rsp_glyph_bits,
   output logic       rsp_last,
   output logic [7:0] rsp_entry_mode,
   output logic [7:0] rsp_display_control,
   output logic [7:0] rsp_shift_control,
   output logic [7:0] rsp_function_set
);

   logic      push;
   entry_type push_entry;
   logic      push_ready;
   logic      pop;
   entry_type pop_entry;
   logic      pop_valid;
   rsp_type   rsp;

   clcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_in_byte(req_in_byte),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   clcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .push_ready(push_ready),
      .pop       (pop),
      .pop_entry (pop_entry),
      .pop_valid (pop_valid)
   );

   clcd_back #(
      .GLYPH_COUNT(GLYPH_COUNT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_valid(pop_valid),
      .pop_entry(pop_entry),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp      (rsp)
   );

   assign rsp_kind            = rsp.kind;
   assign rsp_char_code       = rsp.char_code;
   assign rsp_column          = rsp.column;
   assign rsp_row             = rsp.row;
   assign rsp_glyph_line      = rsp.glyph_line;
   assign rsp_glyph_bits      = rsp.glyph_bits;
   assign rsp_last            = rsp.last;
   assign rsp_entry_mode      = rsp.entry_mode;
   assign rsp_display_control = rsp.display_control;
   assign rsp_shift_control   = rsp.shift_control;
   assign rsp_function_set    = rsp.function_set;

`ifndef ASSERT_OFF
   // clear and text beats are always single results
   a_single_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_ROW) |-> rsp_last)
      else $error("clear or text beat without last");

   a_clear_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_CLEAR) |->
         (rsp_column == 8'd0 && rsp_row == 3'd0 && rsp_char_code == 8'd0))
      else $error("clear beat with nonzero position or code");

   // glyph rows follow each other without a gap
   a_row_follow : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_kind == KIND_ROW && !rsp_last) |=>
         (rsp_valid && rsp_kind == KIND_ROW &&
          rsp_glyph_line == $past(rsp_glyph_line) + 3'd1))
      else $error("glyph row sequence broken");

   a_kind_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind != 2'd3))
      else $error("result kind out of range");
`endif

endmodule

// ----- verif/tb_char_lcd_command_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_char_lcd_command_stream_decoder
// Drives escaped command and data bytes into the display decoder and checks
// every draw, clear and glyph-row beat against a cycle-free model of cursor,
// glyph store and stored command bytes. A short table of directed bytes comes
// first, then random command/data sequences with random sender bursts and
// receiver stalls.
// ----------------------------------------------------------------------------
module tb_char_lcd_command_stream_decoder;
   import clcd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int GLYPH_N      = GLYPH_COUNT_DEFAULT;
   localparam int RANDOM_ITEMS = 140;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PRINT_CAP    = 40;

   // command codes, decoded by the highest set bit
   localparam logic [7:0] CMD_NONE     = 8'h00;
   localparam logic [7:0] CMD_CLEAR    = 8'h01;
   localparam logic [7:0] CMD_HOME     = 8'h02;
   localparam logic [7:0] CMD_ENTRY    = 8'h04;
   localparam logic [7:0] CMD_DISPLAY  = 8'h08;
   localparam logic [7:0] CMD_SHIFT    = 8'h10;
   localparam logic [7:0] CMD_FUNCTION = 8'h20;
   localparam logic [7:0] CMD_CG_ADDR  = 8'h40;
   localparam logic [7:0] CMD_DD_ADDR  = 8'h80;

   typedef struct {
      logic [7:0] in_byte;
      bit         typed;
      rsp_type    want;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_char_code;
   logic [7:0] rsp_column;
   logic [2:0] rsp_row;
   logic [2:0] rsp_glyph_line;
   logic [4:0] rsp_glyph_bits;
   logic       rsp_last;
   logic [7:0] rsp_entry_mode;
   logic [7:0] rsp_display_control;
   logic [7:0] rsp_shift_control;
   logic [7:0] rsp_function_set;

   // model state of the display controller
   bit         esc_armed;
   bit         to_glyph_mem;
   logic [7:0] cur_col;
   logic [2:0] cur_row;
   logic [7:0] glyph_rows [0:63];
   logic [7:0] mode_entry;
   logic [7:0] mode_display;
   logic [7:0] mode_shift;
   logic [7:0] mode_function;

   rsp_type expected_draws [$];
   int      error_count = 0;
   int      beats_in = 0;
   int      beats_out = 0;
   int      kind_seen [0:3];
   int      burst_left = 0;
   int      cycle_count = 0;
   int      stall_mode = 0;
   int      stall_window = 0;

   char_lcd_command_stream_decoder #(
      .GLYPH_COUNT(GLYPH_N)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_char_code      (rsp_char_code),
      .rsp_column         (rsp_column),
      .rsp_row            (rsp_row),
      .rsp_glyph_line     (rsp_glyph_line),
      .rsp_glyph_bits     (rsp_glyph_bits),
      .rsp_last           (rsp_last),
      .rsp_entry_mode     (rsp_entry_mode),
      .rsp_display_control(rsp_display_control),
      .rsp_shift_control  (rsp_shift_control),
      .rsp_function_set   (rsp_function_set)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("beat %0d %s got %h want %h", beats_out, name, got, want));
      end
   endtask

   function automatic rsp_type rsp_lit(input logic [1:0] kind, input logic [7:0] code,
                                       input logic [7:0] col, input logic [2:0] row,
                                       input logic [7:0] em, input logic [7:0] dc,
                                       input logic [7:0] sc, input logic [7:0] fs);
      rsp_type r;
      r.kind            = kind;
      r.char_code       = code;
      r.column          = col;
      r.row             = row;
      r.glyph_line      = 3'd0;
      r.glyph_bits      = 5'd0;
      r.last            = 1'b1;
      r.entry_mode      = em;
      r.display_control = dc;
      r.shift_control   = sc;
      r.function_set    = fs;
      return r;
   endfunction

   function automatic stim_row_type plain(input logic [7:0] b);
      stim_row_type s;
      s.in_byte = b;
      s.typed   = 1'b0;
      s.want    = '0;
      return s;
   endfunction

   function automatic stim_row_type typed_row(input logic [7:0] b, input rsp_type w);
      stim_row_type s;
      s.in_byte = b;
      s.typed   = 1'b1;
      s.want    = w;
      return s;
   endfunction

   function automatic void push_draw(input logic [1:0] kind, input logic [7:0] code,
                                     input logic [2:0] line, input logic [4:0] bits,
                                     input bit last);
      rsp_type r;
      r = rsp_lit(kind, code, cur_col, cur_row, mode_entry, mode_display, mode_shift,
                  mode_function);
      if (kind == KIND_CLEAR) begin
         r.column = 8'd0;
         r.row    = 3'd0;
      end
      r.glyph_line = line;
      r.glyph_bits = bits;
      r.last       = last;
      expected_draws.push_back(r);
   endfunction

   // apply one accepted byte to the model and queue the beats it causes
   task automatic predict_display_byte(input logic [7:0] b);
      int g;
      int l;
      logic [4:0] bits;
      if (esc_armed) begin
         esc_armed = 1'b0;
         if ((b & CMD_DD_ADDR) != 0) begin
            if (b >= DD_LINE0_LO && b <= DD_LINE0_HI) begin
               cur_row = 3'd0;
               cur_col = b - DD_LINE0_LO;
            end
            if (b >= DD_LINE1_LO && b <= DD_LINE1_HI) begin
               cur_row = 3'd1;
               cur_col = b - DD_LINE1_LO;
            end
            if (b >= DD_LINE2_LO && b <= DD_LINE2_HI) begin
               cur_row = 3'd2;
               cur_col = b - DD_LINE2_LO;
            end
            if (b >= DD_LINE3_LO && b <= DD_LINE3_HI) begin
               cur_row = 3'd3;
               cur_col = b - DD_LINE3_LO;
            end
            to_glyph_mem = 1'b0;
         end else if ((b & CMD_CG_ADDR) != 0) begin
            cur_row      = b[5:3];
            cur_col      = 8'd0;
            to_glyph_mem = 1'b1;
         end else if ((b & CMD_FUNCTION) != 0) begin
            mode_function = b;
         end else if ((b & CMD_SHIFT) != 0) begin
            mode_shift = b;
         end else if ((b & CMD_DISPLAY) != 0) begin
            mode_display = b;
         end else if ((b & CMD_ENTRY) != 0) begin
            mode_entry = b;
         end else if ((b & CMD_HOME) != 0) begin
            cur_col = 8'd0;
            cur_row = 3'd0;
         end else if ((b & CMD_CLEAR) != 0) begin
            cur_col    = 8'd0;
            cur_row    = 3'd0;
            mode_entry = mode_entry | ENTRY_INCREMENT_BIT;
            push_draw(KIND_CLEAR, 8'd0, 3'd0, 5'd0, 1'b1);
         end
      end else if (b == ESCAPE_BYTE) begin
         esc_armed = 1'b1;
      end else if (to_glyph_mem) begin
         g = int'(cur_row) % GLYPH_N;
         l = int'(cur_col[2:0]);
         glyph_rows[(g * GLYPH_LINES + l) % 64] = b;
         if (l == 7) begin
            cur_col = 8'd0;
            cur_row = 3'((g + 1) % GLYPH_N);
         end else begin
            cur_col = 8'(l + 1);
         end
      end else if (b <= GLYPH_CODE_HI) begin
         for (int i = 0; i < GLYPH_LINES; i++) begin
            bits = 5'd0;
            if (int'(b) < GLYPH_N) begin
               bits = glyph_rows[(int'(b) * GLYPH_LINES + i) % 64][4:0];
            end
            push_draw(KIND_ROW, b, 3'(i), bits, i == GLYPH_LINES - 1);
         end
         cur_col = cur_col + 8'd1;
      end else if (b >= PRINT_LO && b <= PRINT_HI) begin
         push_draw(KIND_CHAR, b, 3'd0, 5'd0, 1'b1);
         cur_col = cur_col + 8'd1;
      end
   endtask

   // one input beat: bursts of random length separated by random gaps
   task automatic send_beat(input logic [7:0] b, input bit typed, input rsp_type want);
      int gap;
      int n0;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      beats_in++;
      n0 = expected_draws.size();
      predict_display_byte(b);
      if (typed) begin
         while (expected_draws.size() > n0) void'(expected_draws.pop_back());
         expected_draws.push_back(want);
      end
   endtask

   // receiver stall pattern: windows of free flow, light, heavy and periodic stall
   always @(posedge clock) begin
      if (stall_window == 0) begin
         stall_mode   <= $urandom_range(0, 3);
         stall_window <= $urandom_range(8, 60);
      end else begin
         stall_window <= stall_window - 1;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 99) < 30);
         end
         2: begin
            rsp_stall <= ($urandom_range(0, 99) < 75);
         end
         default: begin
            rsp_stall <= (cycle_count % 4) != 0;
         end
      endcase
   end

   always @(posedge clock) begin : rsp_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind            = rsp_kind;
         got.char_code       = rsp_char_code;
         got.column          = rsp_column;
         got.row             = rsp_row;
         got.glyph_line      = rsp_glyph_line;
         got.glyph_bits      = rsp_glyph_bits;
         got.last            = rsp_last;
         got.entry_mode      = rsp_entry_mode;
         got.display_control = rsp_display_control;
         got.shift_control   = rsp_shift_control;
         got.function_set    = rsp_function_set;
         if (expected_draws.size() == 0) begin
            report_mismatch($sformatf("unexpected beat kind %h code %h", got.kind,
                                      got.char_code));
         end else begin
            want = expected_draws.pop_front();
            check_field("kind", 8'(got.kind), 8'(want.kind));
            check_field("char_code", got.char_code, want.char_code);
            check_field("column", got.column, want.column);
            check_field("row", 8'(got.row), 8'(want.row));
            check_field("glyph_line", 8'(got.glyph_line), 8'(want.glyph_line));
            check_field("glyph_bits", 8'(got.glyph_bits), 8'(want.glyph_bits));
            check_field("last", 8'(got.last), 8'(want.last));
            check_field("entry_mode", got.entry_mode, want.entry_mode);
            check_field("display_control", got.display_control, want.display_control);
            check_field("shift_control", got.shift_control, want.shift_control);
            check_field("function_set", got.function_set, want.function_set);
         end
         beats_out++;
         if (got.kind !== 2'bxx) kind_seen[got.kind]++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                  expected_draws.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type directed_rows [$];
      logic [7:0]   rand_bytes [$];
      int           pick;
      int           n;
      rsp_type      none;

      none = '0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      esc_armed     = 1'b0;
      to_glyph_mem  = 1'b0;
      cur_col       = 8'd0;
      cur_row       = 3'd0;
      mode_entry    = ENTRY_MODE_RESET;
      mode_display  = DISPLAY_CONTROL_RESET;
      mode_shift    = SHIFT_CONTROL_RESET;
      mode_function = FUNCTION_SET_RESET;
      foreach (glyph_rows[i]) glyph_rows[i] = 8'h00;

      directed_rows = '{
         typed_row(PRINT_LO, rsp_lit(KIND_CHAR, PRINT_LO, 8'd0, 3'd0, ENTRY_MODE_RESET,
                   DISPLAY_CONTROL_RESET, SHIFT_CONTROL_RESET, FUNCTION_SET_RESET)),
         typed_row(PRINT_HI, rsp_lit(KIND_CHAR, PRINT_HI, 8'd1, 3'd0, ENTRY_MODE_RESET,
                   DISPLAY_CONTROL_RESET, SHIFT_CONTROL_RESET, FUNCTION_SET_RESET)),
         plain(8'h08),                       // unprintable, low end
         plain(8'hFE),                       // unprintable, high end
         plain(ESCAPE_BYTE), plain(CMD_NONE),
         plain(ESCAPE_BYTE),
         typed_row(CMD_CLEAR, rsp_lit(KIND_CLEAR, 8'd0, 8'd0, 3'd0,
                   ENTRY_MODE_RESET | ENTRY_INCREMENT_BIT, DISPLAY_CONTROL_RESET,
                   SHIFT_CONTROL_RESET, FUNCTION_SET_RESET)),
         plain(8'h00),                       // glyph 0, still blank
         plain(ESCAPE_BYTE), plain(CMD_HOME),
         plain(ESCAPE_BYTE), plain(CMD_ENTRY | 8'h01),
         plain(ESCAPE_BYTE), plain(CMD_DISPLAY | 8'h07),
         plain(ESCAPE_BYTE), plain(CMD_SHIFT | 8'h0C),
         plain(ESCAPE_BYTE), plain(CMD_FUNCTION | 8'h1F),
         plain(ESCAPE_BYTE), plain(CMD_CG_ADDR | 8'h38),
         plain(8'h1F), plain(8'hD5),
         // escaped 0xff: off-range address keeps cursor at glyph row 7
         plain(ESCAPE_BYTE), plain(ESCAPE_BYTE),
         plain(GLYPH_CODE_HI),
         plain(ESCAPE_BYTE), plain(DD_LINE3_HI),
         plain(PRINT_HI)
      };

      while (rand_bytes.size() < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            // define glyph rows, then return to display memory
            rand_bytes.push_back(ESCAPE_BYTE);
            rand_bytes.push_back(CMD_CG_ADDR | 8'($urandom_range(0, 63)));
            n = $urandom_range(1, 10);
            repeat (n) rand_bytes.push_back(8'($urandom_range(0, 254)));
            rand_bytes.push_back(ESCAPE_BYTE);
            case ($urandom_range(0, 3))
               0: rand_bytes.push_back(DD_LINE0_LO + 8'($urandom_range(0, 19)));
               1: rand_bytes.push_back(DD_LINE1_LO + 8'($urandom_range(0, 19)));
               2: rand_bytes.push_back(DD_LINE2_LO + 8'($urandom_range(0, 19)));
               default: rand_bytes.push_back(DD_LINE3_LO + 8'($urandom_range(0, 19)));
            endcase
         end else if (pick < 40) begin
            n = $urandom_range(1, 4);
            repeat (n) rand_bytes.push_back(8'($urandom_range(0, GLYPH_CODE_HI)));
         end else if (pick < 60) begin
            n = $urandom_range(1, 6);
            repeat (n) rand_bytes.push_back(8'($urandom_range(PRINT_LO, PRINT_HI)));
         end else if (pick < 80) begin
            rand_bytes.push_back(ESCAPE_BYTE);
            rand_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (pick < 88) begin
            // display address outside all four line ranges
            rand_bytes.push_back(ESCAPE_BYTE);
            if ($urandom_range(0, 1) == 0) begin
               rand_bytes.push_back(8'($urandom_range(8'hA8, 8'hBF)));
            end else begin
               rand_bytes.push_back(8'($urandom_range(8'hE8, 8'hFF)));
            end
         end else begin
            rand_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].in_byte, directed_rows[i].typed, directed_rows[i].want);
      end
      foreach (rand_bytes[i]) send_beat(rand_bytes[i], 1'b0, none);
      req_valid <= 1'b0;

      while (expected_draws.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d bytes in (%0d directed), %0d beats out", beats_in, directed_rows.size(),
               beats_out);
      $display("beats by kind: %0d clear, %0d char, %0d glyph row; %0d mismatches",
               kind_seen[0], kind_seen[1], kind_seen[2], error_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- char_lcd_command_stream_decoder.f -----
rtl/clcd_pkg.sv
rtl/clcd_front.sv
rtl/clcd_queue.sv
rtl/clcd_back.sv
rtl/char_lcd_command_stream_decoder.sv
verif/tb_char_lcd_command_stream_decoder.sv
